// ===== src/rcc_pkg.sv =====
// Package: types, constants and helpers for the range color classifier.
package rcc_pkg;

  localparam int MaxBands  = 16;
  localparam int IdxBits   = $clog2(MaxBands);
  localparam int CntBits   = IdxBits + 1;
  localparam int ValueBits = 32;
  localparam int GapBits   = ValueBits + 1;
  localparam int SumBits   = GapBits + 1;
  localparam int NumBits   = GapBits + 9;

  localparam logic [1:0] KIND_RANGE  = 2'd0;
  localparam logic [1:0] KIND_ALWAYS = 2'd1;

  localparam logic [1:0] LM_NONE  = 2'd0;
  localparam logic [1:0] LM_BELOW = 2'd1;
  localparam logic [1:0] LM_INCL  = 2'd2;
  localparam logic [1:0] LM_EXCL  = 2'd3;

  localparam logic [1:0] UM_SINGLE = 2'd0;
  localparam logic [1:0] UM_EXCL   = 2'd1;
  localparam logic [1:0] UM_INCL   = 2'd2;

  localparam logic [1:0] ST_MATCH  = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_SINGLE = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  localparam logic OP_CLASSIFY = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [31:0] sample;
    logic [3:0]  band_index;
    logic [1:0]  band_kind;
    logic [1:0]  lower_mode;
    logic [31:0] lower_bound;
    logic [1:0]  upper_mode;
    logic [31:0] upper_bound;
    logic [31:0] back_color_in;
    logic [31:0] fore_color_in;
  } rcc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] back_color;
    logic [31:0] fore_color;
  } rcc_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_NEAR, S_DIV, S_DONE
  } rcc_state_t;

endpackage

// ===== src/range_color_classifier.sv =====
// Top level: range color classifier with band table, scan and interpolating divider.
//
// Usage: in_valid/in_ready carry one request (rcc_in_t). A write request
// (operation 1) stores one band in the table and produces no result; it is
// accepted while idle and writes can follow back to back. A classify
// request scans band_count bands, at most 16 (each slot: table read, then
// compare), for the first match, then, if none matched, scans again for the
// nearest range band above and below. When both exist, eight 8-bit channels
// are interpolated on one shared restoring divider. With no match the status
// is none, single (one nearest band) or interpolated. One request is in
// flight at a time; in_ready is low while it is processed. The result sits
// in an output register (out_valid/out_ready); while the receiver stalls the
// block holds the result and accepts no new request. A new request can be
// taken in the cycle after the result is. cfg_we/cfg_wdata write band_count;
// the user must do so only while idle, the block itself does not enforce it.
// After reset the band table is undefined until written, band_count is 0
// and the block is idle.
module range_color_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcc_pkg::rcc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rcc_pkg::rcc_out_t  out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  import rcc_pkg::*;

  logic [1:0]  kind_mem [MaxBands];
  logic [1:0]  lm_mem   [MaxBands];
  logic [31:0] lb_mem   [MaxBands];
  logic [1:0]  um_mem   [MaxBands];
  logic [31:0] ub_mem   [MaxBands];
  logic [31:0] bk_mem   [MaxBands];
  logic [31:0] fg_mem   [MaxBands];

  rcc_state_t state_r, state_nxt;
  logic [4:0]  count_r;
  logic [CntBits-1:0] idx_r, idx_nxt, n_r, n_nxt;
  logic        pass_r, pass_nxt;
  logic signed [31:0] smp_r, smp_nxt;
  logic        hu_r, hu_nxt, hl_r, hl_nxt;
  logic [GapBits-1:0] gu_r, gu_nxt, gl_r, gl_nxt;
  logic [IdxBits-1:0] ui_r, ui_nxt, li_r, li_nxt;
  logic [2:0]  ch_r, ch_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [NumBits-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic        neg_r, neg_nxt;
  logic [8:0]  diff_r, diff_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        ov_r, ov_nxt;
  rcc_out_t    out_r, out_nxt;
  logic        rd_en;
  logic [IdxBits-1:0] rd_addr;

  logic [1:0]  t_kind, t_lm, t_um;
  logic signed [31:0] t_lb, t_ub;
  logic [31:0] t_bk, t_fg, t_bk2, t_fg2;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.operation != OP_CLASSIFY) begin
      kind_mem[in_data.band_index] <= in_data.band_kind;
      lm_mem[in_data.band_index]   <= in_data.lower_mode;
      lb_mem[in_data.band_index]   <= in_data.lower_bound;
      um_mem[in_data.band_index]   <= in_data.upper_mode;
      ub_mem[in_data.band_index]   <= in_data.upper_bound;
      bk_mem[in_data.band_index]   <= in_data.back_color_in;
      fg_mem[in_data.band_index]   <= in_data.fore_color_in;
    end
  end

  // registered table read; second color port reads the upper-nearest band
  always_ff @(posedge clk) begin
    if (rd_en) begin
      t_kind <= kind_mem[rd_addr];
      t_lm   <= lm_mem[rd_addr];
      t_lb   <= lb_mem[rd_addr];
      t_um   <= um_mem[rd_addr];
      t_ub   <= ub_mem[rd_addr];
      t_bk   <= bk_mem[rd_addr];
      t_fg   <= fg_mem[rd_addr];
      t_bk2  <= bk_mem[ui_r];
      t_fg2  <= fg_mem[ui_r];
    end
  end

  logic match;
  logic signed [31:0] eff_hi;
  always_comb begin
    match = 1'b0;
    if (t_kind == KIND_ALWAYS) match = 1'b1;
    else if (t_kind == KIND_RANGE && t_lm != LM_NONE) begin
      if (t_um == UM_SINGLE) begin
        unique case (t_lm)
          LM_BELOW: match = smp_r < t_lb;
          LM_EXCL:  match = smp_r > t_lb;
          default:  match = smp_r == t_lb;
        endcase
      end else if (t_lm == LM_BELOW && smp_r < t_lb) match = 1'b1;
      else if (t_lm == LM_INCL && smp_r < t_lb) match = 1'b0;
      else if (t_lm == LM_EXCL && smp_r <= t_lb) match = 1'b0;
      else if (t_um == UM_EXCL) match = smp_r < t_ub;
      else if (t_um == UM_INCL) match = smp_r <= t_ub;
      else match = 1'b1;
    end
    eff_hi = (t_ub < t_lb) ? t_lb : t_ub;
  end

  logic [GapBits-1:0] gap_a, gap_b;
  assign gap_a = {t_lb[31], t_lb} - {smp_r[31], smp_r};
  assign gap_b = {smp_r[31], smp_r} - {eff_hi[31], eff_hi};

  logic [7:0] ca, cb, chv;
  logic [SumBits-1:0] den;
  logic [NumBits:0] trial;
  assign ca = ch_r[2] ? t_fg[8*ch_r[1:0] +: 8] : t_bk[8*ch_r[1:0] +: 8];
  assign cb = ch_r[2] ? t_fg2[8*ch_r[1:0] +: 8] : t_bk2[8*ch_r[1:0] +: 8];
  assign den = SumBits'(gl_r) + SumBits'(gu_r);
  assign trial = {rem_r, quo_r[NumBits-1]} - (NumBits+1)'(den);

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; n_nxt = n_r; pass_nxt = pass_r;
    smp_nxt = smp_r; hu_nxt = hu_r; hl_nxt = hl_r; gu_nxt = gu_r; gl_nxt = gl_r;
    ui_nxt = ui_r; li_nxt = li_r; ch_nxt = ch_r; step_nxt = step_r;
    rem_nxt = rem_r; quo_nxt = quo_r; neg_nxt = neg_r; diff_nxt = diff_r;
    acc_nxt = acc_r; ov_nxt = ov_r; out_nxt = out_r; chv = '0;
    rd_en = 1'b0; rd_addr = idx_r[IdxBits-1:0];
    in_ready = (state_r == S_IDLE) && !ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready && in_data.operation == OP_CLASSIFY) begin
        smp_nxt = in_data.sample;
        n_nxt = (count_r > 5'(MaxBands)) ? CntBits'(MaxBands) : CntBits'(count_r);
        idx_nxt = '0; pass_nxt = 1'b0; hu_nxt = 1'b0; hl_nxt = 1'b0;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (idx_r == n_r) begin
          if (!pass_r) begin
            pass_nxt = 1'b1; idx_nxt = '0;
          end else if (!hu_r && !hl_r) begin
            out_nxt = '{ST_NONE, 32'd0, 32'd0}; state_nxt = S_DONE;
          end else begin
            rd_en = 1'b1; rd_addr = hl_r ? li_r : ui_r;
            state_nxt = S_NEAR;
          end
        end else begin
          rd_en = 1'b1; state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + 1'b1; state_nxt = S_READ;
        if (!pass_r) begin
          if (match) begin
            out_nxt = '{ST_MATCH, t_bk, t_fg}; state_nxt = S_DONE;
          end
        end else if (t_kind == KIND_RANGE) begin
          if (smp_r < t_lb) begin
            if (!hu_r || gap_a < gu_r) begin
              hu_nxt = 1'b1; gu_nxt = gap_a; ui_nxt = idx_r[IdxBits-1:0];
            end
          end else if (smp_r > eff_hi) begin
            if (!hl_r || gap_b < gl_r) begin
              hl_nxt = 1'b1; gl_nxt = gap_b; li_nxt = idx_r[IdxBits-1:0];
            end
          end
        end
      end
      S_NEAR: begin
        if (!(hu_r && hl_r)) begin
          out_nxt = '{ST_SINGLE, t_bk, t_fg}; state_nxt = S_DONE;
        end else begin
          ch_nxt = '0; step_nxt = '0; state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == 6'd0) begin
          diff_nxt = {1'b0, cb} - {1'b0, ca};
          neg_nxt = diff_nxt[8];
          quo_nxt = NumBits'(gl_r) * NumBits'(diff_nxt[8] ? 9'(-diff_nxt) : diff_nxt);
          rem_nxt = '0; step_nxt = 6'd1;
        end else if (step_r <= 6'(NumBits)) begin
          if (!trial[NumBits]) begin
            rem_nxt = trial[NumBits-1:0]; quo_nxt = {quo_r[NumBits-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[NumBits-2:0], quo_r[NumBits-1]};
            quo_nxt = {quo_r[NumBits-2:0], 1'b0};
          end
          step_nxt = step_r + 1'b1;
        end else begin
          chv = neg_r ? ca - quo_r[7:0] - 8'(rem_r != '0) : ca + quo_r[7:0];
          acc_nxt = {chv, acc_r[63:8]};
          step_nxt = '0; ch_nxt = ch_r + 1'b1;
          if (ch_r == 3'd7) begin
            out_nxt = '{ST_INTERP, acc_nxt[31:0], acc_nxt[63:32]}; state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; count_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
      if (cfg_we) count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; n_r <= n_nxt; pass_r <= pass_nxt; smp_r <= smp_nxt;
    hu_r <= hu_nxt; hl_r <= hl_nxt; gu_r <= gu_nxt; gl_r <= gl_nxt;
    ui_r <= ui_nxt; li_r <= li_nxt; ch_r <= ch_nxt; step_r <= step_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; neg_r <= neg_nxt; diff_r <= diff_nxt;
    acc_r <= acc_nxt; out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid && state_r == S_IDLE) else $error("done lost");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NONE |-> out_data.back_color == 32'd0)
    else $error("none with color");
endmodule
